FILE: hdl/tbfs_pkg.sv
// ----------------------------------------------------------------------------
// tbfs_pkg
// Codes shared by the truss bond force and stiffness unit.
// ----------------------------------------------------------------------------
package tbfs_pkg;

  // coupled column codes
  localparam logic [1:0] COL_X    = 2'd0;
  localparam logic [1:0] COL_Y    = 2'd1;
  localparam logic [1:0] COL_Z    = 2'd2;
  localparam logic [1:0] COL_TEMP = 2'd3;

  // own_component code with no matching row
  localparam logic [1:0] ROW_NONE = 2'd3;

  // register word index
  localparam logic REG_OWN_COMPONENT = 1'b0;

endpackage

FILE: hdl/truss_bond_force_stiffness_unit.sv
// ----------------------------------------------------------------------------
// truss_bond_force_stiffness_unit
// Bond residual and one stiffness entry of a two-node truss bond, fixed point.
// ----------------------------------------------------------------------------
// One bond request is taken in every clock cycle (busy stays low) and its
// result is strobed on done after it passes through the bit-per-stage square
// root pipeline, the three unit-vector divider lanes and the length divider.
// done is a one-cycle strobe and cannot be held off, so results must be taken
// when they appear. own_component may only be written while no request is in
// flight.
module truss_bond_force_stiffness_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] half_dx,
  input  logic signed [DATA_WIDTH-1:0] half_dy,
  input  logic signed [DATA_WIDTH-1:0] half_dz,
  input  logic signed [DATA_WIDTH-1:0] bond_force_value,
  input  logic signed [DATA_WIDTH-1:0] force_per_stretch,
  input  logic signed [DATA_WIDTH-1:0] force_per_temperature,
  input  logic                         bond_intact,
  input  logic [1:0]                   coupled_column,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] residual_first_node,
  output logic signed [DATA_WIDTH-1:0] stiffness_entry,
  output logic                         zero_length,
  output logic                         saturated,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tbfs_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int UW  = F + 2;          // signed unit component
  localparam int PW  = F + 4;          // signed p and q
  localparam int RW2 = W + UW + 1;     // negated residual product
  localparam int TPW = W + UW - F;     // temperature entry before clipping
  localparam int RPW = RW2 - F;        // residual before clipping
  localparam int NW  = W + PW;         // force*q product / length dividend
  localparam int T1W = W + PW - F;
  localparam int SW  = NW + 2;

  typedef struct packed {
    logic [W-1:0]        mx;
    logic [W-1:0]        my;
    logic [W-1:0]        mz;
    logic [2:0]          neg;
    logic signed [W-1:0] bforce;
    logic signed [W-1:0] dfdu;
    logic signed [W-1:0] dfdt;
    logic                intact;
    logic [1:0]          col;
    logic                zero;
  } bond_t;

  typedef struct packed {
    logic signed [RPW-1:0] resid;
    logic signed [TPW-1:0] tmp;
    logic signed [T1W-1:0] t1;
    logic                  fneg;
    logic                  intact;
    logic [1:0]            col;
    logic                  zero;
  } tail_t;

  // configuration port
  logic [1:0] own_component;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign prdata = {30'd0, own_component};

  always_ff @(posedge clk) begin
    if (rst) begin
      own_component <= 2'd0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_OWN_COMPONENT)) begin
      own_component <= pwdata[1:0];
    end
  end

  // input register
  logic  v1;
  bond_t a1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    a1.mx     <= half_dx[W-1] ? W'(-half_dx) : W'(half_dx);
    a1.my     <= half_dy[W-1] ? W'(-half_dy) : W'(half_dy);
    a1.mz     <= half_dz[W-1] ? W'(-half_dz) : W'(half_dz);
    a1.neg    <= {half_dz[W-1], half_dy[W-1], half_dx[W-1]};
    a1.bforce <= bond_force_value;
    a1.dfdu   <= force_per_stretch;
    a1.dfdt   <= force_per_temperature;
    a1.intact <= bond_intact;
    a1.col    <= coupled_column;
    a1.zero   <= 1'b0;
  end

  // squares
  logic         v2;
  bond_t        a2;
  logic [2*W-1:0] sqx, sqy, sqz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    a2  <= a1;
    sqx <= a1.mx * a1.mx;
    sqy <= a1.my * a1.my;
    sqz <= a1.mz * a1.mz;
  end

  // square root, one result bit per stage
  logic           rt_v   [0:W];
  bond_t          rt_a   [0:W];
  logic [2*W-1:0] rt_sq  [0:W];
  logic [W+1:0]   rt_rem [0:W];
  logic [W-1:0]   rt_res [0:W];
  logic [2*W-1:0] sq_sum;
  bond_t          a2z;

  always_comb begin
    sq_sum   = sqx + sqy + sqz;
    a2z      = a2;
    a2z.zero = (sq_sum == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_v[0] <= 1'b0;
    end else begin
      rt_v[0] <= v2;
    end
    rt_sq[0]  <= sq_sum;
    rt_rem[0] <= '0;
    rt_res[0] <= '0;
    rt_a[0]   <= a2z;
  end

  for (genvar k = 0; k < W; k++) begin : g_root
    logic [W+1:0] rem_sh, trial;
    logic         ge;

    always_comb begin
      rem_sh = {rt_rem[k][W-1:0], rt_sq[k][2*W-1:2*W-2]};
      trial  = {rt_res[k], 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_v[k+1] <= 1'b0;
      end else begin
        rt_v[k+1] <= rt_v[k];
      end
      rt_a[k+1]   <= rt_a[k];
      rt_sq[k+1]  <= rt_sq[k] << 2;
      rt_rem[k+1] <= ge ? rem_sh - trial : rem_sh;
      rt_res[k+1] <= {rt_res[k][W-2:0], ge};
    end
  end

  // unit vector, three divider lanes, one quotient bit per stage
  logic              uv_v   [0:F];
  bond_t             uv_a   [0:F];
  logic [W-1:0]      uv_r   [0:F];
  logic [2:0][W-1:0] uv_rem [0:F];
  logic [2:0][F:0]   uv_q   [0:F];
  logic [2:0][W-1:0] mags;

  assign mags = {rt_a[W].mz, rt_a[W].my, rt_a[W].mx};

  always_ff @(posedge clk) begin
    if (rst) begin
      uv_v[0] <= 1'b0;
    end else begin
      uv_v[0] <= rt_v[W];
    end
    uv_a[0] <= rt_a[W];
    uv_r[0] <= rt_res[W];
    for (int i = 0; i < 3; i++) begin
      // the component never exceeds the norm, so the top bit is a compare
      if (mags[i] >= rt_res[W]) begin
        uv_rem[0][i] <= mags[i] - rt_res[W];
        uv_q[0][i]   <= {{F{1'b0}}, 1'b1};
      end else begin
        uv_rem[0][i] <= mags[i];
        uv_q[0][i]   <= '0;
      end
    end
  end

  for (genvar j = 0; j < F; j++) begin : g_unit
    logic [2:0][W:0] rem_sh;
    logic [2:0]      ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem_sh[i] = {uv_rem[j][i], 1'b0};
        ge[i]     = (rem_sh[i] >= {1'b0, uv_r[j]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        uv_v[j+1] <= 1'b0;
      end else begin
        uv_v[j+1] <= uv_v[j];
      end
      uv_a[j+1] <= uv_a[j];
      uv_r[j+1] <= uv_r[j];
      for (int i = 0; i < 3; i++) begin
        uv_rem[j+1][i] <= W'(ge[i] ? rem_sh[i] - {1'b0, uv_r[j]} : rem_sh[i]);
        uv_q[j+1][i]   <= {uv_q[j][i][F-1:0], ge[i]};
      end
    end
  end

  // pick row and column components
  logic               e_v;
  bond_t              e_a;
  logic [W-1:0]       e_r;
  logic signed [UW-1:0] e_urow, e_ucol;
  logic signed [2:0][UW-1:0] uvec;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uvec[i] = uv_a[F].neg[i] ? -$signed({1'b0, uv_q[F][i]}) : $signed({1'b0, uv_q[F][i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else begin
      e_v <= uv_v[F];
    end
    e_a <= uv_a[F];
    e_r <= uv_r[F];
    case (own_component)
      COL_Y:   e_urow <= uvec[1];
      COL_Z:   e_urow <= uvec[2];
      default: e_urow <= uvec[0];
    endcase
    case (uv_a[F].col)
      COL_Y:   e_ucol <= uvec[1];
      COL_Z:   e_ucol <= uvec[2];
      default: e_ucol <= uvec[0];
    endcase
  end

  // first products
  logic                    m_v;
  bond_t                   m_a;
  logic [W-1:0]            m_r;
  logic signed [W+UW-1:0]  m_pres, m_ptmp;
  logic signed [2*UW-1:0]  m_puu;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else begin
      m_v <= e_v;
    end
    m_a    <= e_a;
    m_r    <= e_r;
    m_pres <= e_a.bforce * e_urow;
    m_ptmp <= e_a.dfdt * e_urow;
    m_puu  <= e_urow * e_ucol;
  end

  // scale back, geometric factor q
  logic                  n_v;
  bond_t                 n_a;
  logic [W-1:0]          n_r;
  logic signed [RPW-1:0] n_resid;
  logic signed [TPW-1:0] n_tmp;
  logic signed [PW-1:0]  n_p, n_q;
  logic signed [RW2-1:0] neg_res;
  logic signed [PW-1:0]  p_c, delta;

  always_comb begin
    neg_res = -RW2'(m_pres);
    p_c     = m_puu[2*UW-1:F];
    delta   = (m_a.col == own_component) ? $signed({{(PW-F-1){1'b0}}, 1'b1, {F{1'b0}}})
                                         : $signed(PW'(0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_v <= 1'b0;
    end else begin
      n_v <= m_v;
    end
    n_a     <= m_a;
    n_r     <= m_r;
    n_resid <= neg_res[RW2-1:F];
    n_tmp   <= m_ptmp[W+UW-1:F];
    n_p     <= p_c;
    n_q     <= delta - p_c;
  end

  // second products
  logic                  o_v;
  bond_t                 o_a;
  logic [W-1:0]          o_r;
  logic signed [RPW-1:0] o_resid;
  logic signed [TPW-1:0] o_tmp;
  logic signed [NW-1:0]  o_pfq, o_ppd;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else begin
      o_v <= n_v;
    end
    o_a     <= n_a;
    o_r     <= n_r;
    o_resid <= n_resid;
    o_tmp   <= n_tmp;
    o_pfq   <= n_a.bforce * n_q;
    o_ppd   <= n_a.dfdu * n_p;
  end

  // force*q over the full length 2r, one quotient bit per stage
  logic          ld_v   [0:NW];
  tail_t         ld_t   [0:NW];
  logic [W:0]    ld_d   [0:NW];
  logic [NW-1:0] ld_n   [0:NW];
  logic [W:0]    ld_rem [0:NW];
  logic [NW-1:0] ld_q   [0:NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      ld_v[0] <= 1'b0;
    end else begin
      ld_v[0] <= o_v;
    end
    ld_t[0].resid  <= o_resid;
    ld_t[0].tmp    <= o_tmp;
    ld_t[0].t1     <= o_ppd[NW-1:F];
    ld_t[0].fneg   <= o_pfq[NW-1];
    ld_t[0].intact <= o_a.intact;
    ld_t[0].col    <= o_a.col;
    ld_t[0].zero   <= o_a.zero;
    ld_d[0]        <= {o_r, 1'b0};
    ld_n[0]        <= o_pfq[NW-1] ? NW'(-o_pfq) : NW'(o_pfq);
    ld_rem[0]      <= '0;
    ld_q[0]        <= '0;
  end

  for (genvar k = 0; k < NW; k++) begin : g_len
    logic [W+1:0] rem_sh;
    logic         ge;

    always_comb begin
      rem_sh = {ld_rem[k], ld_n[k][NW-1]};
      ge     = (rem_sh >= {1'b0, ld_d[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ld_v[k+1] <= 1'b0;
      end else begin
        ld_v[k+1] <= ld_v[k];
      end
      ld_t[k+1]   <= ld_t[k];
      ld_d[k+1]   <= ld_d[k];
      ld_n[k+1]   <= ld_n[k] << 1;
      ld_rem[k+1] <= (W+1)'(ge ? rem_sh - {1'b0, ld_d[k]} : rem_sh);
      ld_q[k+1]   <= {ld_q[k][NW-2:0], ge};
    end
  end

  // sum, saturate, deliver
  tail_t               f_t;
  logic signed [NW:0]  t2;
  logic signed [SW-1:0] sum;
  logic                active, r_ovf, s_ovf, tp_ovf;
  logic signed [W-1:0] r_clip, s_clip, tp_clip;
  logic [W-1:0]        w_max, w_min;

  assign f_t   = ld_t[NW];
  assign w_max = {1'b0, {(W-1){1'b1}}};
  assign w_min = {1'b1, {(W-1){1'b0}}};

  always_comb begin
    t2  = f_t.fneg ? -$signed({1'b0, ld_q[NW]}) : $signed({1'b0, ld_q[NW]});
    sum = SW'(f_t.t1) + SW'(t2);
    active = f_t.intact && (own_component != ROW_NONE) && !f_t.zero;

    r_ovf  = !((&f_t.resid[RPW-1:W-1]) || !(|f_t.resid[RPW-1:W-1]));
    r_clip = r_ovf ? (f_t.resid[RPW-1] ? w_min : w_max) : f_t.resid[W-1:0];

    s_ovf  = !((&sum[SW-1:W-1]) || !(|sum[SW-1:W-1]));
    s_clip = s_ovf ? (sum[SW-1] ? w_min : w_max) : sum[W-1:0];

    tp_ovf  = !((&f_t.tmp[TPW-1:W-1]) || !(|f_t.tmp[TPW-1:W-1]));
    tp_clip = tp_ovf ? (f_t.tmp[TPW-1] ? w_min : w_max) : f_t.tmp[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ld_v[NW];
    end
    zero_length <= f_t.zero;
    if (active) begin
      residual_first_node <= r_clip;
      if (f_t.col == COL_TEMP) begin
        stiffness_entry <= tp_clip;
        saturated       <= r_ovf || tp_ovf;
      end else begin
        stiffness_entry <= s_clip;
        saturated       <= r_ovf || s_ovf;
      end
    end else begin
      residual_first_node <= '0;
      stiffness_entry     <= '0;
      saturated           <= 1'b0;
    end
  end

endmodule

FILE: bench/truss_bond_force_stiffness_unit_test.sv
// ----------------------------------------------------------------------------
// truss_bond_force_stiffness_unit_test
// Self-checking bench for the truss bond residual and stiffness unit: directed
// bonds with a few hand-computed results, then random bonds under several
// own_component settings and start gaps, all checked against a bit-exact
// fixed-point predictor of the bond kernel.
// ----------------------------------------------------------------------------
module truss_bond_force_stiffness_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tbfs_pkg::*;

  localparam int FRAC = 16;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] hx, hy, hz, bforce, dfdu, dfdt;
    logic               intact;
    logic [1:0]         col;
  } bond_t;

  typedef struct packed {
    logic signed [31:0] resid, stiff;
    logic               zl, sat;
  } bond_result_t;

  typedef struct {
    bond_t        b;
    bit           known;
    bond_result_t want;
  } bond_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, zero_length, saturated, pready;
  logic signed [31:0] half_dx = '0, half_dy = '0, half_dz = '0;
  logic signed [31:0] bond_force_value = '0, force_per_stretch = '0;
  logic signed [31:0] force_per_temperature = '0;
  logic bond_intact = 1'b0;
  logic [1:0] coupled_column = COL_X;
  logic signed [31:0] residual_first_node, stiffness_entry;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;

  logic [1:0] own_row = 2'd0;
  bond_result_t pending_results[$];
  bond_row_t directed[$];
  int errors = 0;
  int idle_pct = 0;

  always #5 clk = ~clk;

  truss_bond_force_stiffness_unit i_dut (.*);

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clip_word(longint v, inout bit sat);
    if (v > WMAX) begin
      sat = 1;
      return WMAX;
    end
    if (v < WMIN) begin
      sat = 1;
      return WMIN;
    end
    return v;
  endfunction

  function automatic bond_result_t predict_bond(bond_t b, logic [1:0] row);
    longint h[3], u[3];
    longint unsigned m, sq, r;
    longint fv, p, q, t1, t2;
    bond_result_t res;
    bit sat;
    res = '0;
    sat = 0;
    h[0] = b.hx;
    h[1] = b.hy;
    h[2] = b.hz;
    fv = b.bforce;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      m = (h[i] < 0) ? -h[i] : h[i];
      sq += m * m;
    end
    if (sq == 0) begin
      res.zl = 1'b1;
      return res;
    end
    r = isqrt(sq);
    for (int i = 0; i < 3; i++) begin
      m = (h[i] < 0) ? -h[i] : h[i];
      m = (m << FRAC) / r;
      u[i] = (h[i] < 0) ? -longint'(m) : longint'(m);
    end
    if (b.intact && row != ROW_NONE) begin
      res.resid = 32'(clip_word((-(fv * u[row])) >>> FRAC, sat));
      if (b.col == COL_TEMP) begin
        res.stiff = 32'(clip_word((u[row] * longint'(b.dfdt)) >>> FRAC, sat));
      end else begin
        p = (u[row] * u[b.col]) >>> FRAC;
        q = ((row == b.col) ? (64'sd1 <<< FRAC) : 64'sd0) - p;
        t1 = (p * longint'(b.dfdu)) >>> FRAC;
        t2 = (fv * q) / longint'(2 * r);
        res.stiff = 32'(clip_word(t1 + t2, sat));
      end
    end
    res.sat = sat;
    return res;
  endfunction

  function automatic bond_t mk_bond(int hx, int hy, int hz, int f, int du, int dt,
                                    bit intact, logic [1:0] col);
    bond_t b;
    b = '{hx, hy, hz, f, du, dt, intact, col};
    return b;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h0;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
      default: return $urandom_range(0, 32'h001f_ffff) - 32'h0010_0000;
    endcase
  endfunction

  function automatic bond_t rand_bond();
    bond_t b;
    b.hx = rand_word();
    b.hy = rand_word();
    b.hz = ($urandom_range(0, 3) == 0) ? 32'h0 : rand_word();
    if ($urandom_range(0, 19) == 0) begin
      b.hx = 0;
      b.hy = 0;
      b.hz = 0;
    end
    b.bforce = rand_word();
    b.dfdu = rand_word();
    b.dfdt = rand_word();
    b.intact = ($urandom_range(0, 9) != 0);
    b.col = 2'($urandom_range(0, 3));
    return b;
  endfunction

  // request goes out on a falling edge and stays until taken
  task automatic issue_bond(bond_t b);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    half_dx <= b.hx;
    half_dy <= b.hy;
    half_dz <= b.hz;
    bond_force_value <= b.bforce;
    force_per_stretch <= b.dfdu;
    force_per_temperature <= b.dfdt;
    bond_intact <= b.intact;
    coupled_column <= b.col;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    start <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[2] == REG_OWN_COMPONENT) own_row = data[1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // scoreboard: check the strobed result, then log the request taken now
  always @(posedge clk) begin
    bond_result_t got, want;
    bond_row_t row_item;
    if (!rst && done) begin
      got = '{residual_first_node, stiffness_entry, zero_length, saturated};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("result mismatch: expected %p got %p", want, got);
        end
      end
    end
    if (!rst && start && !busy) begin
      row_item.b = '{half_dx, half_dy, half_dz, bond_force_value, force_per_stretch,
                     force_per_temperature, bond_intact, coupled_column};
      pending_results.insert(pending_results.size(), predict_bond(row_item.b, own_row));
    end
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [1:0] settings[8];
    int pcts[4];
    bond_row_t r;
    settings = '{2'd1, 2'd2, ROW_NONE, 2'd0, 2'd2, 2'd1, 2'd0, 2'd2};
    pcts = '{0, 49, 14, 0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed bonds at reset setting (x row)
    directed.insert(directed.size(), '{mk_bond(0, 0, 0, 32'h10000, 5, 5, 1, COL_X), 1,
                         '{32'sd0, 32'sd0, 1'b1, 1'b0}});
    directed.insert(directed.size(), '{mk_bond(32'h10000, 0, 0, 32'h10000, 5, 5, 0, COL_X), 1,
                         '{32'sd0, 32'sd0, 1'b0, 1'b0}});
    // unit bond along x: residual -F, diagonal entry is dFdU
    directed.insert(directed.size(),
                    '{mk_bond(32'h10000, 0, 0, 32'h10000, 32'h20000, 0, 1, COL_X), 1,
                      '{-32'sh10000, 32'sh20000, 1'b0, 1'b0}});
    // most negative force saturates the residual
    directed.insert(directed.size(),
                    '{mk_bond(32'h10000, 0, 0, 32'h8000_0000, 0, 0, 1, COL_TEMP), 1,
                      '{32'sh7fff_ffff, 32'sd0, 1'b0, 1'b1}});
    for (int c = 0; c < 4; c++) begin
      directed.insert(directed.size(), '{mk_bond(32'h30000, -32'h40000, 32'h1234, 32'h7fff_ffff,
                                   32'h8000_0000, 32'h7fff_ffff, 1, 2'(c)), 0, '0});
      directed.insert(directed.size(), '{mk_bond(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1, 2'(c)),
                                         0, '0});
      directed.insert(directed.size(), '{mk_bond(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                   -32'h1_0000, 32'h1, -32'h1, 1, 2'(c)), 0, '0});
      directed.insert(directed.size(),
                      '{mk_bond(1, -1, 0, 32'h50000, -32'h30000, 32'h20000, 1, 2'(c)), 0, '0});
    end
    foreach (directed[i]) begin
      r = directed[i];
      issue_bond(r.b);
      if (r.known && predict_bond(r.b, own_row) !== r.want) begin
        errors++;
        if (errors <= 10) $display("directed row %0d: hand value differs from prediction", i);
      end
    end
    drain();

    // write to an unmapped word must not disturb the row
    apb_write(3'd4, 32'h2);
    for (int ph = 0; ph < 8; ph++) begin
      apb_write(3'd0, {30'h0, settings[ph]});
      idle_pct = pcts[ph % 4];
      for (int n = 0; n < 200; n++) begin
        if (n >= 100 && n < 130) idle_pct = 0;
        else idle_pct = pcts[ph % 4];
        issue_bond(rand_bond());
      end
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/tbfs_pkg.sv
hdl/truss_bond_force_stiffness_unit.sv
bench/truss_bond_force_stiffness_unit_test.sv
